>>> rtl/keyed_tbcd_digit_scrambler_defines.svh
// ----------------------------------------------------------------------------
// Keyed TBCD digit scrambler assertion macros
// Concurrent assertion helpers shared by the scrambler RTL.
// ----------------------------------------------------------------------------
`ifndef KEYED_TBCD_DIGIT_SCRAMBLER_DEFINES_SVH
`define KEYED_TBCD_DIGIT_SCRAMBLER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define KTS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KTS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define KTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/kts_pkg.sv
// ----------------------------------------------------------------------------
// Keyed TBCD digit scrambler package
// Sizes, register indexes and small constant-divisor helpers.
// ----------------------------------------------------------------------------
package kts_pkg;

    localparam int BYTE_COUNT          = 8;
    localparam int NIBBLE_COUNT        = 2 * BYTE_COUNT;
    localparam int WORD_W              = 64;
    localparam int MAX_KEY_CHARS       = 16;
    localparam int CHARS_PER_REG       = 8;
    localparam int CHAR_W              = 7;
    localparam int DIG_W               = 4;
    localparam int POS_W               = 4;
    localparam int KEY_IDX_W           = 4;
    localparam int LEN_W               = 5;
    localparam int CFG_DATA_W          = 63;
    localparam int CFG_IDX_W           = 2;

    localparam logic [LEN_W-1:0]     CLEAR_PREFIX_DIGITS = 5'd5;
    localparam logic [LEN_W-1:0]     MAX_LEN             = 5'd16;
    localparam logic [DIG_W-1:0]     FILLER              = 4'hF;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

    // x / 10 by reciprocal, exact for every 8-bit x
    function automatic logic [4:0] div10(input logic [7:0] x);
        logic [15:0] prod;
        prod = {8'd0, x} * 16'd205;
        return prod[15:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [7:0] x);
        logic [7:0] rem;
        rem = x - ({3'd0, div10(x)} * 8'd10);
        return rem[3:0];
    endfunction

endpackage

>>> rtl/kts_key_store.sv
// ----------------------------------------------------------------------------
// Key store
// Holds key characters, their tens values and the saturated key length.
// ----------------------------------------------------------------------------
module kts_key_store (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kts_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [kts_pkg::KEY_IDX_W-1:0]       i_fwd_idx,
    input  logic [kts_pkg::KEY_IDX_W-1:0]       i_back_idx,
    output logic [kts_pkg::CHAR_W-1:0]          o_fwd_char,
    output logic [kts_pkg::DIG_W-1:0]           o_back_tens,
    output logic [kts_pkg::LEN_W-1:0]           o_len
);

    logic [kts_pkg::MAX_KEY_CHARS-1:0][kts_pkg::CHAR_W-1:0] r_key;
    logic [kts_pkg::MAX_KEY_CHARS-1:0][kts_pkg::DIG_W-1:0]  r_tens;
    logic [kts_pkg::LEN_W-1:0]                              r_len_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_tens    <= '0;
            r_len_raw <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kts_pkg::REG_KEY_LOW: begin
                    for (int i = 0; i < kts_pkg::CHARS_PER_REG; i++) begin
                        r_key[i]  <= i_cfg_data[i*8 +: kts_pkg::CHAR_W];
                        r_tens[i] <= 4'(kts_pkg::div10({1'b0, i_cfg_data[i*8 +: 7]}));
                    end
                end
                kts_pkg::REG_KEY_HIGH: begin
                    for (int i = 0; i < kts_pkg::CHARS_PER_REG; i++) begin
                        r_key[kts_pkg::CHARS_PER_REG+i]  <= i_cfg_data[i*8 +: kts_pkg::CHAR_W];
                        r_tens[kts_pkg::CHARS_PER_REG+i] <=
                            4'(kts_pkg::div10({1'b0, i_cfg_data[i*8 +: 7]}));
                    end
                end
                kts_pkg::REG_KEY_LEN: begin
                    r_len_raw <= i_cfg_data[kts_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_fwd_char  = r_key[i_fwd_idx];
    assign o_back_tens = r_tens[i_back_idx];
    assign o_len       = (r_len_raw > kts_pkg::MAX_LEN) ? kts_pkg::MAX_LEN : r_len_raw;

endmodule

>>> rtl/kts_digit_unit.sv
// ----------------------------------------------------------------------------
// Digit unit
// Shared per-digit arithmetic: ((k + d) mod 10 + tens) mod 10.
// ----------------------------------------------------------------------------
module kts_digit_unit (
    input  logic [kts_pkg::CHAR_W-1:0] i_key_char,
    input  logic [kts_pkg::DIG_W-1:0]  i_back_tens,
    input  logic [kts_pkg::DIG_W-1:0]  i_digit,
    output logic [kts_pkg::DIG_W-1:0]  o_digit
);

    logic [7:0] w_sum;
    logic [3:0] w_mod;
    logic [4:0] w_tot;

    always_comb begin
        w_sum = {1'b0, i_key_char} + {4'd0, i_digit};
        w_mod = kts_pkg::mod10(w_sum);
        w_tot = {1'b0, i_back_tens} + {1'b0, w_mod};
        if (w_tot >= 5'd20) begin
            o_digit = 4'(w_tot - 5'd20);
        end else if (w_tot >= 5'd10) begin
            o_digit = 4'(w_tot - 5'd10);
        end else begin
            o_digit = w_tot[3:0];
        end
    end

endmodule

>>> rtl/keyed_tbcd_digit_scrambler.sv
// ----------------------------------------------------------------------------
// Keyed TBCD digit scrambler
// Scrambles the digits of a packed TBCD identity under a configured key.
// ----------------------------------------------------------------------------
// One item at a time. After the input transfer, a single digit unit walks the
// nibbles one per cycle until the first filler or the last nibble, then the
// result is held until its output transfer; the input is stalled throughout.
// With a zero key length the walk is skipped. A new item is therefore taken
// only after the previous result has been transferred out.
`include "keyed_tbcd_digit_scrambler_defines.svh"

module keyed_tbcd_digit_scrambler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [kts_pkg::WORD_W-1:0]         i_identity_tbcd,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [kts_pkg::WORD_W-1:0]         o_scrambled_tbcd,
    input  logic                               i_cfg_we,
    input  logic [kts_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kts_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                             r_state, n_state;
    logic [kts_pkg::WORD_W-1:0]         r_word, n_word;
    logic [kts_pkg::LEN_W-1:0]          r_len, n_len;
    logic [kts_pkg::POS_W-1:0]          r_pos, n_pos;
    logic [kts_pkg::KEY_IDX_W-1:0]      r_fwd, n_fwd;
    logic [kts_pkg::KEY_IDX_W-1:0]      r_back, n_back;
    logic                               r_back_up, n_back_up;

    logic [kts_pkg::LEN_W-1:0]          w_len;
    logic [kts_pkg::LEN_W-1:0]          w_len_dec;
    logic [kts_pkg::CHAR_W-1:0]         w_fwd_char;
    logic [kts_pkg::DIG_W-1:0]          w_back_tens;
    logic [kts_pkg::DIG_W-1:0]          w_digit;
    logic [kts_pkg::DIG_W-1:0]          w_new_digit;
    logic                               w_in_xfer;
    logic                               w_out_xfer;

    kts_key_store u_key_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fwd_idx   (r_fwd),
        .i_back_idx  (r_back),
        .o_fwd_char  (w_fwd_char),
        .o_back_tens (w_back_tens),
        .o_len       (w_len)
    );

    kts_digit_unit u_digit_unit (
        .i_key_char  (w_fwd_char),
        .i_back_tens (w_back_tens),
        .i_digit     (w_digit),
        .o_digit     (w_new_digit)
    );

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = (r_state == S_DONE);
    assign o_scrambled_tbcd = r_word;
    assign w_in_xfer        = i_valid && !o_stall;
    assign w_out_xfer       = o_valid && !i_stall;
    assign w_len_dec        = w_len - 5'd1;
    assign w_digit          = r_word[{r_pos, 2'b00} +: kts_pkg::DIG_W];

    always_comb begin
        n_state   = r_state;
        n_word    = r_word;
        n_len     = r_len;
        n_pos     = r_pos;
        n_fwd     = r_fwd;
        n_back    = r_back;
        n_back_up = r_back_up;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_word    = i_identity_tbcd;
                    n_len     = w_len;
                    n_pos     = '0;
                    n_fwd     = '0;
                    n_back    = w_len_dec[kts_pkg::KEY_IDX_W-1:0];
                    n_back_up = 1'b0;
                    n_state   = (w_len == '0) ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (w_digit == kts_pkg::FILLER) begin
                    n_state = S_DONE;
                end else begin
                    if ({1'b0, r_pos} >= kts_pkg::CLEAR_PREFIX_DIGITS) begin
                        n_word[{r_pos, 2'b00} +: kts_pkg::DIG_W] = w_new_digit;
                    end
                    n_pos = r_pos + 4'd1;
                    n_fwd = (({1'b0, r_fwd} + 5'd1) == r_len) ? '0 : r_fwd + 4'd1;
                    if (!r_back_up) begin
                        if (r_back == '0) begin
                            n_back    = (r_len == 5'd1) ? 4'd0 : 4'd1;
                            n_back_up = 1'b1;
                        end else begin
                            n_back = r_back - 4'd1;
                        end
                    end else begin
                        n_back = (({1'b0, r_back} + 5'd1) == r_len) ? '0 : r_back + 4'd1;
                    end
                    if (r_pos == 4'(kts_pkg::NIBBLE_COUNT - 1)) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_out_xfer) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word    <= n_word;
        r_len     <= n_len;
        r_pos     <= n_pos;
        r_fwd     <= n_fwd;
        r_back    <= n_back;
        r_back_up <= n_back_up;
    end

    `KTS_ASSERT_IMPLIES(a_fwd_in_key, i_clk, i_rst_n, r_state == S_RUN, ({1'b0, r_fwd} < r_len), "forward key index out of range")
    `KTS_ASSERT_IMPLIES(a_back_in_key, i_clk, i_rst_n, r_state == S_RUN, ({1'b0, r_back} < r_len), "backward key index out of range")
    `KTS_ASSERT_NEXT(a_zero_key_pass, i_clk, i_rst_n, w_in_xfer && (w_len == '0), o_valid && (o_scrambled_tbcd == $past(i_identity_tbcd)), "zero key length did not pass word through")
    `KTS_ASSERT_IMPLIES(a_busy_when_result, i_clk, i_rst_n, o_valid, o_stall, "input taken while result pending")

endmodule

>>> sim/keyed_tbcd_digit_scrambler_checker.sv
// ----------------------------------------------------------------------------
// Keyed TBCD digit scrambler checker
// Watches the key register port and both data channels, predicts each
// scrambled identity from the live key and compares it on output transfer.
// ----------------------------------------------------------------------------
module keyed_tbcd_digit_scrambler_checker
    import kts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [WORD_W-1:0]     i_identity_tbcd,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [WORD_W-1:0]     i_scrambled_tbcd,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RADIX      = 10;
    localparam int BYTE_W     = 8;
    localparam int MAX_REPORT = 10;

    logic [CFG_DATA_W-1:0] key_low;
    logic [CFG_DATA_W-1:0] key_high;
    logic [LEN_W-1:0]      key_len;
    logic [WORD_W-1:0]     pending_scrambled[$];

    function automatic int unsigned key_char(input int unsigned idx);
        if (idx < CHARS_PER_REG)
            return key_low[idx*BYTE_W +: CHAR_W];
        return key_high[(idx - CHARS_PER_REG)*BYTE_W +: CHAR_W];
    endfunction

    function automatic logic [WORD_W-1:0] scramble_identity(input logic [WORD_W-1:0] ident);
        logic [WORD_W-1:0] w;
        int unsigned       len;
        int unsigned       d;
        int unsigned       back;
        int unsigned       n;
        w   = ident;
        len = (key_len > MAX_LEN) ? MAX_LEN : key_len;
        if (len != 0) begin
            for (int p = 0; p < NIBBLE_COUNT; p++) begin
                d = w[p*DIG_W +: DIG_W];
                if (d == FILLER)
                    break;
                if (p >= CLEAR_PREFIX_DIGITS) begin
                    back = (p + 1 <= len) ? len - p - 1 : p + 1 - len;
                    back = back % len;
                    n    = (key_char(p % len) + d) % RADIX;
                    w[p*DIG_W +: DIG_W] = DIG_W'((key_char(back) / RADIX + n) % RADIX);
                end
            end
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        logic [WORD_W-1:0] want;
        if (!i_rst_n) begin
            key_low  = '0;
            key_high = '0;
            key_len  = '0;
            pending_scrambled.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KEY_LOW:  key_low  = i_cfg_data;
                    REG_KEY_HIGH: key_high = i_cfg_data;
                    REG_KEY_LEN:  key_len  = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_scrambled.size() == 0) begin
                    if (o_mismatches < MAX_REPORT)
                        $display("%t: unexpected result %h", $realtime, i_scrambled_tbcd);
                    o_mismatches++;
                end else begin
                    want = pending_scrambled.pop_front();
                    if (i_scrambled_tbcd !== want) begin
                        if (o_mismatches < MAX_REPORT)
                            $display("%t: scrambled_tbcd expected %h actual %h",
                                     $realtime, want, i_scrambled_tbcd);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_scrambled.push_back(scramble_identity(i_identity_tbcd));
        end
        o_pending = pending_scrambled.size();
    end

endmodule

>>> sim/tb_keyed_tbcd_digit_scrambler.sv
// ----------------------------------------------------------------------------
// Keyed TBCD digit scrambler testbench
// Drives corner identities and random identities under a series of keys,
// with random gaps and output stalls; the checker scores every transfer.
// ----------------------------------------------------------------------------
module tb_keyed_tbcd_digit_scrambler;
    import kts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0]  REG_SPARE     = 2'd3;
    localparam logic [CFG_DATA_W-1:0] KEY_ALL_ONES  = '1;
    localparam int                    SETTLE_CYCLES = 24;
    localparam int                    CORNER_COUNT  = 12;
    localparam int                    PHASE_COUNT   = 10;
    localparam int                    PHASE_ITEMS   = 200;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_valid          = 1'b0;
    logic [WORD_W-1:0]     i_identity_tbcd  = '0;
    logic                  i_stall          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [WORD_W-1:0]     o_scrambled_tbcd;
    int                    mismatches;
    int                    pending;
    bit                    quiet            = 1'b0;

    keyed_tbcd_digit_scrambler u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_identity_tbcd  (i_identity_tbcd),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_scrambled_tbcd (o_scrambled_tbcd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    keyed_tbcd_digit_scrambler_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_identity_tbcd  (i_identity_tbcd),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_scrambled_tbcd (o_scrambled_tbcd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // output back-pressure
    initial begin
        int unsigned r;
        int unsigned hold;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (quiet || r < 50) begin
                i_stall <= 1'b0;
                hold = $urandom_range(1, 20);
            end else if (r < 92) begin
                i_stall <= 1'b1;
                hold = $urandom_range(1, 3);
            end else begin
                i_stall <= 1'b1;
                hold = $urandom_range(10, 40);
            end
            repeat (hold - 1) @(negedge i_clk);
        end
    end

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [WORD_W-1:0] corner_identity(input int idx);
        case (idx)
            0:       return 64'h0000_0000_0000_0000;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            2:       return 64'h9999_9999_9999_9999;
            3:       return 64'hEEEE_EEEE_EEEE_EEEE;
            4:       return 64'hAAAA_BBBB_CCCC_DDDD;
            5:       return 64'hFEDC_BA98_7654_3210;
            6:       return 64'h1234_5678_9F01_2345;
            7:       return 64'h0123_4567_89AB_F123;
            8:       return 64'h5555_5555_555F_4444;
            9:       return 64'h3210_F987_6543_2109;
            10:      return 64'h0FFF_FFFF_FF98_7654;
            default: return 64'h8000_0000_0000_0000;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_identity();
        logic [WORD_W-1:0] w;
        int unsigned       r;
        int unsigned       ndig;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            // real subscriber number: digits then filler padding
            ndig = $urandom_range(1, NIBBLE_COUNT);
            for (int p = 0; p < NIBBLE_COUNT; p++)
                w[p*DIG_W +: DIG_W] = (p < ndig) ? DIG_W'($urandom_range(0, 9)) : FILLER;
        end else if (r < 80) begin
            for (int p = 0; p < NIBBLE_COUNT; p++)
                w[p*DIG_W +: DIG_W] = DIG_W'($urandom_range(0, 14));
            if ($urandom_range(0, 1))
                w[$urandom_range(0, NIBBLE_COUNT-1)*DIG_W +: DIG_W] = FILLER;
        end else begin
            w = {$urandom, $urandom};
        end
        return w;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_key();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return KEY_ALL_ONES;
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    function automatic logic [LEN_W-1:0] random_key_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return LEN_W'(1);
        if (r == 2)
            return MAX_LEN;
        if (r == 3)
            return LEN_W'($urandom_range(17, 31));
        return LEN_W'($urandom_range(2, 15));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_key(input logic [CFG_DATA_W-1:0] low,
                            input logic [CFG_DATA_W-1:0] high,
                            input logic [LEN_W-1:0]      len);
        logic [CFG_DATA_W-1:0] len_word;
        drain();
        len_word = CFG_DATA_W'({$urandom, $urandom});
        if ($urandom_range(0, 1))
            len_word = '0;
        len_word[LEN_W-1:0] = len;
        write_reg(REG_KEY_LOW, low);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_SPARE, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_KEY_HIGH, high);
        write_reg(REG_KEY_LEN, len_word);
    endtask

    task automatic send_identity(input logic [WORD_W-1:0] word);
        int unsigned gap;
        i_valid         <= 1'b1;
        i_identity_tbcd <= word;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        gap = idle_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset key: zero length, word passes through
        send_identity(corner_identity(0));
        send_identity(corner_identity(2));
        send_identity(corner_identity(3));
        send_identity(corner_identity(5));
        i_valid <= 1'b0;

        load_key(KEY_ALL_ONES, KEY_ALL_ONES, MAX_LEN);
        for (int i = 0; i < CORNER_COUNT; i++)
            send_identity(corner_identity(i));
        i_valid <= 1'b0;

        load_key(63'h0102_0304_0506_0708, '0, LEN_W'(1));
        send_identity(corner_identity(2));
        send_identity(corner_identity(4));
        send_identity(corner_identity(9));
        i_valid <= 1'b0;

        // length above the maximum saturates
        load_key(random_key(), random_key(), LEN_W'(31));
        send_identity(corner_identity(2));
        send_identity(corner_identity(5));
        send_identity(corner_identity(6));
        i_valid <= 1'b0;

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            load_key(random_key(), random_key(), random_key_len());
            quiet = (ph % 4 == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_identity(random_identity());
            i_valid <= 1'b0;
        end

        quiet = 1'b0;
        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> keyed_tbcd_digit_scrambler.f
+incdir+rtl
rtl/kts_pkg.sv
rtl/kts_key_store.sv
rtl/kts_digit_unit.sv
rtl/keyed_tbcd_digit_scrambler.sv
sim/keyed_tbcd_digit_scrambler_checker.sv
sim/tb_keyed_tbcd_digit_scrambler.sv
